FILE: src/integer_stack_machine_assert.svh
// Assertion macros for the integer stack machine checker.
// Depends on nothing; included by files that assert.
`ifndef INTEGER_STACK_MACHINE_ASSERT_SVH
`define INTEGER_STACK_MACHINE_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define ISM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("ism assertion failed");

// Clocked assertion that also holds across reset.
`define ISM_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ism assertion failed");

`endif

FILE: src/ism_pkg.sv
// Shared types and constants of the integer stack machine.
// No dependencies; imported by the front, back, top level and checker.
package ism_pkg;

    localparam int VALUE_W       = 32;
    localparam int ACTION_W      = 3;
    localparam int STATUS_W      = 3;
    localparam int STACK_DEPTH_D = 64;

    // Raw action codes on the input port.
    localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PALL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PTOP = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SWAP = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_NOP  = 3'd6;

    typedef enum logic [2:0] {
        OP_PUSH, OP_PALL, OP_PTOP, OP_POP, OP_SWAP, OP_ADD, OP_NOP, OP_UNKNOWN
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_TOP_EMPTY  = 3'd1,
        STAT_POP_EMPTY  = 3'd2,
        STAT_SWAP_SHORT = 3'd3,
        STAT_ADD_SHORT  = 3'd4,
        STAT_UNKNOWN    = 3'd5,
        STAT_OVERFLOW   = 3'd6,
        STAT_HALTED     = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_B, S_WR_B, S_WR_A, S_DONE, S_PTOP, S_PALL
    } t_state;

    // Request as queued between front and back.
    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    // One result as held in the output register.
    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic                      present;
        logic                      last;
    } t_result;

endpackage

FILE: src/ism_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/ism_front.sv
// Front end: accepts requests, decodes the action, holds two in a queue.
// Depends on ism_pkg.
module ism_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic [ism_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [ism_pkg::VALUE_W-1:0]  i_push_value,
    output logic                                full,
    output logic                                o_req_valid,
    output ism_pkg::t_req                       o_req,
    input  logic                                i_req_take
);
    import ism_pkg::*;

    t_req       r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       wr, rd;
    t_op        dec_op;

    always_comb begin
        case (i_action)
            ACT_PUSH: dec_op = OP_PUSH;
            ACT_PALL: dec_op = OP_PALL;
            ACT_PTOP: dec_op = OP_PTOP;
            ACT_POP:  dec_op = OP_POP;
            ACT_SWAP: dec_op = OP_SWAP;
            ACT_ADD:  dec_op = OP_ADD;
            ACT_NOP:  dec_op = OP_NOP;
            default:  dec_op = OP_UNKNOWN;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_slot[r_rptr];
    assign wr          = push && !full;
    assign rd          = o_req_valid && i_req_take;

    always_comb begin
        n_wptr = wr ? !r_wptr : r_wptr;
        n_rptr = rd ? !r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wptr] <= '{op: dec_op, value: i_push_value};
        end
    end
endmodule

FILE: src/ism_back.sv
// Back end: executes queued requests against the stack RAM, fills the result register.
// Depends on ism_pkg and ism_ram.
module ism_back #(
    parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_D
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  ism_pkg::t_req   i_req,
    output logic            o_req_take,
    output logic            o_res_valid,
    output ism_pkg::t_result o_res,
    input  logic            i_res_pop
);
    import ism_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_halted, n_halted;
    t_op                r_op, n_op;
    logic [VALUE_W-1:0] r_a, n_a;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [VALUE_W-1:0] wdata, rdata;

    logic          out_free, cnt_zero, cnt_short, cnt_full, multi, take;
    logic [CW-1:0] cnt_m1, cnt_m2;
    logic [AW-1:0] top_addr, sec_addr, push_addr;
    t_status       single_status;

    ism_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free  = !r_out_valid || i_res_pop;
    assign cnt_zero  = (r_count == '0);
    assign cnt_short = (r_count < CW'(2));
    assign cnt_full  = (r_count == CW'(STACK_DEPTH));
    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m2    = r_count - CW'(2);
    assign top_addr  = cnt_m1[AW-1:0];
    assign sec_addr  = cnt_m2[AW-1:0];
    assign push_addr = AW'(r_count);

    // Requests that continue in later states and need no result slot now.
    assign multi = !r_halted &&
                   (((i_req.op == OP_PALL) || (i_req.op == OP_PTOP)) && !cnt_zero ||
                    ((i_req.op == OP_SWAP) || (i_req.op == OP_ADD)) && !cnt_short);
    assign take  = (r_state == S_IDLE) && i_req_valid && (multi || out_free);
    assign o_req_take = take;

    always_comb begin
        single_status = STAT_OK;
        if (r_halted) begin
            single_status = STAT_HALTED;
        end else begin
            case (i_req.op)
                OP_PUSH:    single_status = cnt_full  ? STAT_OVERFLOW   : STAT_OK;
                OP_PTOP:    single_status = STAT_TOP_EMPTY;
                OP_POP:     single_status = cnt_zero  ? STAT_POP_EMPTY  : STAT_OK;
                OP_SWAP:    single_status = STAT_SWAP_SHORT;
                OP_ADD:     single_status = STAT_ADD_SHORT;
                OP_UNKNOWN: single_status = STAT_UNKNOWN;
                default:    single_status = STAT_OK;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && multi) begin
                    case (i_req.op)
                        OP_PALL: n_state = S_PALL;
                        OP_PTOP: n_state = S_PTOP;
                        default: n_state = S_RD_B;
                    endcase
                end
            end
            S_RD_B: n_state = S_WR_B;
            S_WR_B: n_state = (r_op == OP_SWAP) ? S_WR_A : S_DONE;
            S_WR_A: n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            S_PTOP: n_state = out_free ? S_IDLE : S_PTOP;
            S_PALL: n_state = (out_free && (r_idx == '0)) ? S_IDLE : S_PALL;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    always_comb begin
        n_count     = r_count;
        n_halted    = r_halted;
        n_op        = r_op;
        n_a         = r_a;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_res_pop;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = top_addr;
        wdata       = rdata;
        re          = 1'b0;
        raddr       = top_addr;
        case (r_state)
            S_IDLE: begin
                if (take && multi) begin
                    re    = 1'b1;
                    n_op  = i_req.op;
                    n_idx = top_addr;
                end else if (take) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: single_status, value: '0, present: 1'b0, last: 1'b1};
                    if (!r_halted) begin
                        if (single_status != STAT_OK) begin
                            n_halted = 1'b1;
                        end else if (i_req.op == OP_PUSH) begin
                            we      = 1'b1;
                            waddr   = push_addr;
                            wdata   = i_req.value;
                            n_count = r_count + CW'(1);
                        end else if (i_req.op == OP_POP) begin
                            n_count = cnt_m1;
                        end
                    end
                end
            end
            S_RD_B: begin
                // rdata holds the top entry; fetch the one below it.
                n_a   = rdata;
                re    = 1'b1;
                raddr = sec_addr;
            end
            S_WR_B: begin
                we = 1'b1;
                if (r_op == OP_SWAP) begin
                    waddr = top_addr;
                    wdata = rdata;
                end else begin
                    waddr   = sec_addr;
                    wdata   = rdata + r_a;
                    n_count = cnt_m1;
                end
            end
            S_WR_A: begin
                we    = 1'b1;
                waddr = sec_addr;
                wdata = r_a;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: STAT_OK, value: '0, present: 1'b0, last: 1'b1};
                end
            end
            S_PTOP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: STAT_OK, value: rdata, present: 1'b1, last: 1'b1};
                end
            end
            S_PALL: begin
                // One element per cycle while the output keeps draining.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: STAT_OK, value: rdata, present: 1'b1,
                              last: (r_idx == '0)};
                    if (r_idx != '0) begin
                        re    = 1'b1;
                        raddr = r_idx - AW'(1);
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_res_pop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
endmodule

FILE: src/integer_stack_machine.sv
// Top level of the integer stack machine: front decoder/queue, back executor.
// Depends on ism_pkg, ism_front, ism_back (and ism_ram below it).
//
// Usage:
//   Request channel: drive i_action/i_push_value and raise push; the request is
//   taken on a clock edge with push high and full low. A two-entry queue sits in
//   front, so requests keep being taken while the executor is busy.
//   Result channel: while empty is low, o_status/o_item_value/o_value_present/
//   o_last_result show the oldest result; pop takes it. o_last_result marks the
//   final result of a request; only print-all gives more than one.
//   In the executor, push, pop, nop, errors and halted requests complete in the
//   idle state; print-top reads the top entry, then gives it; print-all reads
//   one element after another; add and swap read the top two entries, then
//   write back, swap twice: the stack RAM has a single registered read port
//   and a single write port. A request passes the queue and the result register.
//   Any error halts the block: later requests each give one "halted" result.
//   Reset (synchronous, active low) empties both queues, clears the element
//   count and the halt flag; RAM contents are not cleared and not needed.
//   If the receiver stalls, the result register holds; the executor waits and
//   the input queue fills, then full rises.
module integer_stack_machine #(
    parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ism_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [ism_pkg::VALUE_W-1:0]  i_push_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [ism_pkg::STATUS_W-1:0]        o_status,
    output logic signed [ism_pkg::VALUE_W-1:0]  o_item_value,
    output logic                                o_value_present,
    output logic                                o_last_result
);
    import ism_pkg::*;

    logic    req_valid;
    t_req    req;
    logic    req_take;
    logic    res_valid;
    t_result res;

    // Front: decode and queue requests.
    ism_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .full         (full),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_take   (req_take)
    );

    // Back: execute against the stack RAM, own the result register.
    ism_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign o_status        = res.status;
    assign o_item_value    = res.value;
    assign o_value_present = res.present;
    assign o_last_result   = res.last;
endmodule

FILE: src/ism_checker.sv
// Port-level checker for the integer stack machine, bound to the top level.
// Depends on ism_pkg and integer_stack_machine_assert.svh.
`include "integer_stack_machine_assert.svh"

module ism_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic [ism_pkg::STATUS_W-1:0]        o_status,
    input logic signed [ism_pkg::VALUE_W-1:0]  o_item_value,
    input logic                                o_value_present,
    input logic                                o_last_result
);
    import ism_pkg::*;

    // Printed values only come with an ok status.
    `ISM_ASSERT(a_print_ok, i_clk, i_rst_n, !empty && o_value_present |-> o_status == STAT_OK)
    // Any error or halted result closes its request.
    `ISM_ASSERT(a_err_last, i_clk, i_rst_n, !empty && o_status != STAT_OK |-> o_last_result)
    // Non-printing results carry a zero value.
    `ISM_ASSERT(a_zero_val, i_clk, i_rst_n, !empty && !o_value_present |-> o_item_value == '0)
    // A stalled result holds.
    `ISM_ASSERT(a_stall_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_status) && $stable(o_item_value))
    // Reset empties both sides.
    `ISM_ASSERT_NORST(a_reset_clear, i_clk, !i_rst_n |=> empty && !full)
endmodule

bind integer_stack_machine ism_checker u_ism_checker (.*);
